### src/tfra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged field record assembler package
// Shared widths, codes and bundle types of the record assembler.
// ----------------------------------------------------------------------------
package tfra_pkg;

   localparam int SlotCount = 6;
   localparam int IdWidth   = 11;
   localparam int WordWidth = 32;
   localparam int CsrIndexWidth = 3;

   localparam logic [SlotCount-1:0] FullMask = '1;
   localparam logic [WordWidth-1:0] TimeoutReset = 32'd1000;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] REG_ID_RMS         = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_ID_CREST       = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_ID_PEAK        = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_ID_TEMPERATURE = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_ID_CURRENT     = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_ID_SPEED       = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_TIMEOUT        = 3'd6;

   typedef enum logic {
      CMD_FIELD = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [IdWidth-1:0]   msg_id;
      logic [WordWidth-1:0] field_word;
      logic [WordWidth-1:0] time_now;
   } item_type;

   typedef struct packed {
      logic [SlotCount-1:0][IdWidth-1:0] ids;
      logic [WordWidth-1:0]              timeout_limit;
   } cfg_type;

   typedef struct packed {
      logic                                record_done;
      logic                                record_dropped;
      logic [SlotCount-1:0]                present_bits;
      logic [SlotCount-1:0][WordWidth-1:0] words;
   } result_type;

endpackage : tfra_pkg
`default_nettype wire

### src/tagged_field_record_assembler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged field record assembler
// Collects six tagged measurement words into one record and emits it when
// complete; tick words discard a partial record that has aged too long.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  req_*     in         tuser: cmd; tdata: msg_id, field_word, time_now
//  rsp_*     out        tuser: record_done, record_dropped; tdata: mask, words
//  csr_*     in         register index and write data, always ready
//
// One word is accepted every cycle while the result register is not stalled; the
// input register holds the word and the result register takes its result when
// the held word advances.
// Reset loads the identifier and timeout defaults and empties the record.
// A stalled result register holds the input register, which then drops
// req_tready; no word is lost or processed twice.
// ----------------------------------------------------------------------------
module tagged_field_record_assembler_top
   import tfra_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Input words.
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [79:0]              req_tdata,  // msg_id, field_word, time_now
   input  wire logic [0:0]               req_tuser,  // cmd
   // Results.
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [199:0]             rsp_tdata,  // present_bits, out_rms, out_crest,
                                                     // out_peak, out_temperature,
                                                     // out_current, out_speed
   output      logic [1:0]               rsp_tuser,  // record_done, record_dropped
   // Configuration writes.
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [WordWidth-1:0]     csr_data
);

   cfg_type    cfg_ff, cfg_in;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   result_type result;
   logic       advance;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == REG_TIMEOUT) begin
            cfg_in.timeout_limit = csr_data;
         end else if (csr_index < REG_TIMEOUT) begin
            cfg_in.ids[csr_index] = csr_data[IdWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SlotCount; i++) begin
            cfg_ff.ids[i] <= IdWidth'(i);
         end
         cfg_ff.timeout_limit <= TimeoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The held word is processed when the result register is free or drains.
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.cmd        <= cmd_type'(req_tuser[0]);
         item_ff.msg_id     <= req_tdata[10:0];
         item_ff.field_word <= req_tdata[42:11];
         item_ff.time_now   <= req_tdata[74:43];
      end
   end

   tfra_record u_record (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.record_dropped, rsp_ff.record_done};
   assign rsp_tdata  = {2'b00, rsp_ff.words, rsp_ff.present_bits};

`ifndef SYNTHESIS
   a_done_or_drop : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff.record_done && rsp_ff.record_dropped))
      else $error("record completed and dropped by the same word");

   a_done_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.record_done) |-> (rsp_ff.present_bits == '0))
      else $error("completed record left present bits set");

   a_never_full : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_ff.present_bits != FullMask))
      else $error("full record was not emitted");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while the held word is stalled");
`endif

endmodule : tagged_field_record_assembler_top
`default_nettype wire

### src/tfra_record.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged field record assembler: record state
// Holds the six slot words, the present mask and the first arrival time, and
// works out the result of one word in a single pass.
// ----------------------------------------------------------------------------
module tfra_record
   import tfra_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output      result_type result
);

   logic [SlotCount-1:0][WordWidth-1:0] slot_ff, slot_in;
   logic [SlotCount-1:0]                mask_ff, mask_in;
   logic [WordWidth-1:0]                first_ff, first_in;

   logic [SlotCount-1:0] hit_vec;
   logic                 hit_any;
   logic                 is_field;
   logic [SlotCount-1:0] mask_set;
   logic [WordWidth-1:0] age;
   logic                 done;
   logic                 stale;

   // The lowest slot whose identifier matches takes the word.
   always_comb begin
      logic found;
      found   = 1'b0;
      hit_vec = '0;
      for (int i = 0; i < SlotCount; i++) begin
         if (!found && cfg.ids[i] == item.msg_id) begin
            hit_vec[i] = 1'b1;
            found      = 1'b1;
         end
      end
   end

   assign hit_any  = |hit_vec;
   assign is_field = (item.cmd == CMD_FIELD);
   assign mask_set = mask_ff | hit_vec;
   assign age      = item.time_now - first_ff;
   assign done     = is_field && hit_any && (mask_set == FullMask);
   assign stale    = !is_field && (mask_ff != '0) && (age > cfg.timeout_limit);

   always_comb begin
      for (int i = 0; i < SlotCount; i++) begin
         slot_in[i] = (is_field && hit_vec[i]) ? item.field_word : slot_ff[i];
      end

      if (done || stale) begin
         mask_in = '0;
      end else if (is_field) begin
         mask_in = mask_set;
      end else begin
         mask_in = mask_ff;
      end

      first_in = (is_field && hit_any && mask_ff == '0) ? item.time_now : first_ff;
   end

   always_comb begin
      result.record_done    = done;
      result.record_dropped = stale;
      result.present_bits   = mask_in;
      result.words          = done ? slot_in : '0;
   end

   // Slot words and the time stamp are only read once a present bit covers
   // them, so they carry no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (advance) begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff  <= slot_in;
         first_ff <= first_in;
      end
   end

endmodule : tfra_record
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tagged field record assembler testbench
// Drives tagged measurement words and timeout ticks into the assembler with
// random gaps on both streams, predicts every result from a local model of
// the slot store, present mask and arrival stamp, and checks each result
// field by field in order. Directed cases come first, followed by random
// traffic under several register settings.
// ----------------------------------------------------------------------------
module testbench;
   import tfra_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 8;
   localparam int MaxReports  = 10;
   localparam logic [CsrIndexWidth-1:0] RegUnused = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [79:0]              req_tdata;   // msg_id, field_word, time_now
   logic [0:0]               req_tuser;   // cmd
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [199:0]             rsp_tdata;   // present_bits, out_rms, out_crest, out_peak,
                                          // out_temperature, out_current, out_speed
   logic [1:0]               rsp_tuser;   // record_done, record_dropped
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [WordWidth-1:0]     csr_data;

   tagged_field_record_assembler_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Local copy of the configuration and the partial record.
   logic [IdWidth-1:0]   cfg_ids [SlotCount];
   logic [WordWidth-1:0] cfg_timeout;
   logic [WordWidth-1:0] slot_words [SlotCount];
   logic [SlotCount-1:0] present_mask;
   logic [WordWidth-1:0] first_stamp;

   result_type           pending_results [$];
   logic [WordWidth-1:0] clock_ms;
   bit                   idle_enable = 1'b1;
   int                   mismatches = 0;
   int                   words_sent = 0;
   int                   ticks_sent = 0;
   int                   records_done = 0;
   int                   records_dropped = 0;
   int                   settings_used = 0;
   int                   cycles = 0;

   string slot_names [SlotCount] = '{"out_rms", "out_crest", "out_peak",
                                     "out_temperature", "out_current", "out_speed"};

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_enable || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_record();
      for (int i = 0; i < SlotCount; i++) slot_words[i] = '0;
      present_mask = '0;
      first_stamp  = '0;
   endfunction

   function automatic void reset_predictor();
      for (int i = 0; i < SlotCount; i++) cfg_ids[i] = IdWidth'(i);
      cfg_timeout = TimeoutReset;
      clear_record();
   endfunction

   // Advances the local record by one word and returns the result it causes.
   function automatic result_type assemble_step(item_type it);
      result_type           res;
      int                   hit;
      logic [WordWidth-1:0] age;
      res = '0;
      hit = -1;
      if (it.cmd == CMD_FIELD) begin
         // The lowest slot wins when an identifier is configured twice.
         for (int i = SlotCount - 1; i >= 0; i--) begin
            if (cfg_ids[i] == it.msg_id) hit = i;
         end
         if (hit >= 0) begin
            if (present_mask == '0) first_stamp = it.time_now;
            slot_words[hit]   = it.field_word;
            present_mask[hit] = 1'b1;
            if (present_mask == FullMask) begin
               for (int i = 0; i < SlotCount; i++) res.words[i] = slot_words[i];
               res.record_done = 1'b1;
               clear_record();
            end
         end
      end else if (present_mask != '0) begin
         age = it.time_now - first_stamp;
         if (age > cfg_timeout) begin
            res.record_dropped = 1'b1;
            clear_record();
         end
      end
      res.present_bits = present_mask;
      return res;
   endfunction

   task automatic send_item(input cmd_type cmd, input logic [IdWidth-1:0] id,
                            input logic [WordWidth-1:0] word,
                            input logic [WordWidth-1:0] now_ms);
      item_type   it;
      result_type res;
      int         gap;
      it.cmd        = cmd;
      it.msg_id     = id;
      it.field_word = word;
      it.time_now   = now_ms;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, now_ms, word, id};
      do @(posedge clock); while (!req_tready);
      res = assemble_step(it);
      pending_results.push_back(res);
      if (cmd == CMD_TICK) ticks_sent++;
      else words_sent++;
      if (res.record_done) records_done++;
      if (res.record_dropped) records_dropped++;
   endtask

   // Stops the sender and waits until every result has come out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CsrIndexWidth-1:0] idx,
                          input logic [WordWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx < SlotCount) cfg_ids[idx] = data[IdWidth-1:0];
      else if (idx == REG_TIMEOUT) cfg_timeout = data;
   endtask

   task automatic program_config(input logic [SlotCount-1:0][IdWidth-1:0] ids,
                                 input logic [WordWidth-1:0] limit,
                                 input bit poke_unused);
      drain_results();
      // Upper data bits are set on purpose; only the identifier width counts.
      csr_put(REG_ID_RMS,         {21'($urandom_range(0, 2**21 - 1)), ids[0]});
      csr_put(REG_ID_CREST,       {21'($urandom_range(0, 2**21 - 1)), ids[1]});
      csr_put(REG_ID_PEAK,        {21'($urandom_range(0, 2**21 - 1)), ids[2]});
      csr_put(REG_ID_TEMPERATURE, {21'($urandom_range(0, 2**21 - 1)), ids[3]});
      csr_put(REG_ID_CURRENT,     {21'($urandom_range(0, 2**21 - 1)), ids[4]});
      csr_put(REG_ID_SPEED,       {21'($urandom_range(0, 2**21 - 1)), ids[5]});
      csr_put(REG_TIMEOUT,        limit);
      if (poke_unused) csr_put(RegUnused, $urandom);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic note_mismatch(input string what, input logic [WordWidth-1:0] exp_value,
                                input logic [WordWidth-1:0] act_value);
      mismatches++;
      if (mismatches <= MaxReports)
         $display("MISMATCH %s: expected %h actual %h", what, exp_value, act_value);
   endtask

   task automatic check_result();
      result_type exp_res;
      if (pending_results.size() == 0) begin
         note_mismatch("result with nothing expected", '0, {26'b0, rsp_tdata[5:0]});
         return;
      end
      exp_res = pending_results.pop_front();
      if (rsp_tuser[0] !== exp_res.record_done)
         note_mismatch("record_done", WordWidth'(exp_res.record_done),
                       WordWidth'(rsp_tuser[0]));
      if (rsp_tuser[1] !== exp_res.record_dropped)
         note_mismatch("record_dropped", WordWidth'(exp_res.record_dropped),
                       WordWidth'(rsp_tuser[1]));
      if (rsp_tdata[5:0] !== exp_res.present_bits)
         note_mismatch("present_bits", WordWidth'(exp_res.present_bits),
                       WordWidth'(rsp_tdata[5:0]));
      for (int i = 0; i < SlotCount; i++) begin
         if (rsp_tdata[6 + 32*i +: 32] !== exp_res.words[i])
            note_mismatch(slot_names[i], exp_res.words[i], rsp_tdata[6 + 32*i +: 32]);
      end
   endtask

   // Result side: sample each accepted word, then pick the next ready level.
   initial begin
      int stall;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tagged_field_record_assembler_top regression: fail");
         $finish;
      end
   end

   // Reset defaults, unknown and duplicate words, the timeout boundary with a
   // wrapping clock, a full record and a tick on an empty record.
   task automatic test_directed_defaults();
      send_item(CMD_TICK,  11'h7FF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(CMD_FIELD, 11'd0,   32'h0000_0000, 32'hFFFF_FFF0);
      send_item(CMD_FIELD, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFF8);
      send_item(CMD_FIELD, 11'd1,   32'hFFFF_FFFF, 32'h0000_0000);
      send_item(CMD_FIELD, 11'd1,   32'hA5A5_A5A5, 32'h0000_0005);
      // Age equal to the limit keeps the record; one more millisecond drops it.
      send_item(CMD_TICK,  11'd0,   32'h0000_0000, 32'h0000_03D8);
      send_item(CMD_TICK,  11'h7FF, 32'h5A5A_5A5A, 32'h0000_03D9);
      send_item(CMD_FIELD, 11'd5,   32'hFFFF_FFFF, 32'h0000_0400);
      send_item(CMD_FIELD, 11'd4,   32'h0000_0000, 32'h0000_0401);
      send_item(CMD_FIELD, 11'd3,   32'h8000_0001, 32'h0000_0402);
      send_item(CMD_FIELD, 11'd2,   32'h7FFF_FFFE, 32'h0000_0403);
      send_item(CMD_FIELD, 11'd1,   32'h1234_5678, 32'h0000_0404);
      send_item(CMD_FIELD, 11'd0,   32'hDEAD_BEEF, 32'h0000_0405);
      send_item(CMD_FIELD, 11'd3,   32'h0F0F_0F0F, 32'h7FFF_FFFF);
      send_item(CMD_TICK,  11'd3,   32'hFFFF_FFFF, 32'h7FFF_FFFF);
   endtask

   // Shared identifiers, extreme identifiers, a zero and a maximum timeout,
   // and a write to the unused register index.
   task automatic test_directed_config();
      logic [SlotCount-1:0][IdWidth-1:0] ids;
      ids[0] = 11'h7FF;
      ids[1] = 11'h7FF;
      ids[2] = 11'd0;
      ids[3] = 11'd1024;
      ids[4] = 11'd1;
      ids[5] = 11'd2046;
      program_config(ids, 32'd0, 1'b1);
      send_item(CMD_FIELD, 11'h7FF, 32'hC001_D00D, 32'd10);
      send_item(CMD_TICK,  11'd0,   32'd0,         32'd10);
      send_item(CMD_TICK,  11'd0,   32'd0,         32'd11);
      // The crest slot shares its identifier with rms and never fills.
      send_item(CMD_FIELD, 11'd0,    32'h1111_1111, 32'd20);
      send_item(CMD_FIELD, 11'd1024, 32'h2222_2222, 32'd21);
      send_item(CMD_FIELD, 11'd1,    32'h3333_3333, 32'd22);
      send_item(CMD_FIELD, 11'd2046, 32'h4444_4444, 32'd23);
      send_item(CMD_FIELD, 11'h7FF,  32'h5555_5555, 32'd24);
      program_config(ids, 32'hFFFF_FFFF, 1'b0);
      send_item(CMD_TICK,  11'd0,   32'd0,         32'd19);
      program_config(ids, 32'd5, 1'b0);
      send_item(CMD_TICK,  11'd0,   32'd0,         32'd26);
   endtask

   function automatic logic [SlotCount-1:0][IdWidth-1:0] distinct_ids();
      logic [SlotCount-1:0][IdWidth-1:0] ids;
      bit                                clash;
      for (int i = 0; i < SlotCount; i++) begin
         do begin
            ids[i] = IdWidth'($urandom_range(0, 2047));
            clash = 1'b0;
            for (int j = 0; j < i; j++) if (ids[j] == ids[i]) clash = 1'b1;
         end while (clash);
      end
      return ids;
   endfunction

   // Mostly words for configured slots, some unknown identifiers and ticks;
   // the clock creeps forward with an occasional jump across the wrap.
   task automatic run_traffic(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain_results();
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 96) clock_ms = clock_ms + $urandom_range(0, 60);
         else clock_ms = $urandom;
         if (r < 72)
            send_item(CMD_FIELD, cfg_ids[$urandom_range(0, SlotCount - 1)], $urandom,
                      clock_ms);
         else if (r < 82)
            send_item(CMD_FIELD, IdWidth'($urandom_range(0, 2047)), $urandom, clock_ms);
         else
            send_item(CMD_TICK, IdWidth'($urandom_range(0, 2047)), $urandom, clock_ms);
      end
   endtask

   task automatic test_random_settings();
      logic [SlotCount-1:0][IdWidth-1:0] ids;
      clock_ms = $urandom;

      program_config(distinct_ids(), $urandom_range(100, 400), 1'b0);
      run_traffic(110);

      // A stretch without idling on either side, with two slots sharing one identifier.
      ids = distinct_ids();
      ids[$urandom_range(3, 5)] = ids[$urandom_range(0, 2)];
      idle_enable = 1'b0;
      program_config(ids, 32'hFFFF_FFFF, 1'b0);
      run_traffic(110);
      idle_enable = 1'b1;

      ids[0] = 11'd0;
      ids[1] = 11'h7FF;
      ids[2] = 11'd1;
      ids[3] = 11'h7FE;
      ids[4] = 11'h400;
      ids[5] = 11'h3FF;
      program_config(ids, 32'd0, 1'b0);
      run_traffic(110);

      program_config(distinct_ids(), $urandom, 1'b1);
      run_traffic(110);

      for (int i = 0; i < SlotCount; i++) ids[i] = IdWidth'(i);
      program_config(ids, TimeoutReset, 1'b1);
      run_traffic(110);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_ID_RMS;
      csr_data   <= '0;
      reset_predictor();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_directed_config();
      test_random_settings();
      drain_results();

      $display("Sent %0d field words and %0d ticks over %0d register settings.",
               words_sent, ticks_sent, settings_used);
      $display("Saw %0d completed records and %0d stale records dropped.",
               records_done, records_dropped);
      if (mismatches == 0) begin
         $display("tagged_field_record_assembler_top regression: pass");
      end else begin
         $display("%0d mismatches in total.", mismatches);
         $display("tagged_field_record_assembler_top regression: fail");
      end
      $finish;
   end

endmodule : testbench

### sim.f
src/tfra_pkg.sv
src/tfra_record.sv
src/tagged_field_record_assembler_top.sv
dv/testbench.sv
